// ===== sv/fthash_pkg.sv =====
// Shared types, constants and mix helper for the flow tuple bucket hash.
`timescale 1ns / 1ps
package fthash_pkg;

  localparam int unsigned WORD_W      = 32;
  localparam int unsigned MIX_LINES   = 9;
  localparam logic [WORD_W-1:0] GOLDEN_WORD        = 32'h9e37_79b9;
  localparam logic [WORD_W-1:0] BUCKET_COUNT_RESET = 32'd1024;

  // Shift amount of each mix line, in order
  localparam int unsigned MIX_SHIFT [MIX_LINES] = '{13, 8, 13, 12, 16, 5, 3, 10, 15};

  typedef logic [WORD_W-1:0] word_t;

  // Flow five-tuple as carried through the front of the pipeline
  typedef struct packed {
    logic [31:0] source_address;
    logic [31:0] destination_address;
    logic [15:0] source_port;
    logic [15:0] destination_port;
    logic [7:0]  protocol_number;
  } tuple_t;

  // One lookup2 mix line: x -= y; x -= z; x ^= z shifted
  function automatic word_t mix_line(input word_t x, input word_t y, input word_t z,
                                     input logic [4:0] sh, input logic left);
    word_t d;
    d = x - y - z;
    mix_line = left ? (d ^ (z << sh)) : (d ^ (z >> sh));
  endfunction

endpackage

// ===== sv/fthash_if.sv =====
// Valid/ready channel interfaces for the tuple input and the bucket output.
`timescale 1ns / 1ps
interface fthash_tuple_if;
  logic        valid;
  logic        ready;
  logic [31:0] source_address;
  logic [31:0] destination_address;
  logic [15:0] source_port;
  logic [15:0] destination_port;
  logic [7:0]  protocol_number;

  modport source (output valid, source_address, destination_address, source_port,
                  destination_port, protocol_number, input ready);
  modport sink (input valid, source_address, destination_address, source_port,
                destination_port, protocol_number, output ready);
endinterface

interface fthash_bucket_if;
  logic        valid;
  logic        ready;
  logic [31:0] bucket_index;

  modport source (output valid, bucket_index, input ready);
  modport sink (input valid, bucket_index, output ready);
endinterface

// ===== sv/fthash_mix.sv =====
// Seed/add stage followed by one register stage per lookup2 mix line.
`timescale 1ns / 1ps
module fthash_mix (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  fthash_pkg::tuple_t  tuple,
  input  fthash_pkg::word_t   bucket_count,
  output logic                out_valid,
  output fthash_pkg::word_t   hash
);
  import fthash_pkg::*;

  word_t a [MIX_LINES+1];
  word_t b [MIX_LINES+1];
  word_t c [MIX_LINES+1];
  logic  valid [MIX_LINES+1];

  // Seed stage: golden word plus tuple fields and bucket count
  always_ff @(posedge clk) begin
    if (rst) begin
      valid[0] <= 1'b0;
    end else if (en) begin
      valid[0] <= in_valid;
    end
    if (en) begin
      a[0] <= GOLDEN_WORD + tuple.source_address + {16'd0, tuple.destination_port};
      b[0] <= GOLDEN_WORD + tuple.destination_address + {24'd0, tuple.protocol_number};
      c[0] <= GOLDEN_WORD + {16'd0, tuple.source_port} + bucket_count;
    end
  end

  // One mix line per stage; the updated word rotates a, b, c
  for (genvar k = 0; k < MIX_LINES; k++) begin : g_line
    localparam logic [4:0] SH = 5'(MIX_SHIFT[k]);
    always_ff @(posedge clk) begin
      if (rst) begin
        valid[k+1] <= 1'b0;
      end else if (en) begin
        valid[k+1] <= valid[k];
      end
      if (en) begin
        if (k % 3 == 0) begin
          a[k+1] <= mix_line(a[k], b[k], c[k], SH, 1'b0);
          b[k+1] <= b[k];
          c[k+1] <= c[k];
        end else if (k % 3 == 1) begin
          a[k+1] <= a[k];
          b[k+1] <= mix_line(b[k], c[k], a[k], SH, 1'b1);
          c[k+1] <= c[k];
        end else begin
          a[k+1] <= a[k];
          b[k+1] <= b[k];
          c[k+1] <= mix_line(c[k], a[k], b[k], SH, 1'b0);
        end
      end
    end
  end

  assign out_valid = valid[MIX_LINES];
  assign hash      = c[MIX_LINES];

endmodule

// ===== sv/fthash_mod.sv =====
// Pipelined restoring remainder: one quotient bit per register stage.
`timescale 1ns / 1ps
module fthash_mod (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  fthash_pkg::word_t  dividend,
  input  fthash_pkg::word_t  divisor,
  output logic               out_valid,
  output fthash_pkg::word_t  remainder
);
  import fthash_pkg::*;

  // Stage k registers; bits holds the dividend bits not yet consumed
  word_t rem   [WORD_W];
  word_t bits  [WORD_W-1];
  logic  valid [WORD_W];

  // Shift in the next dividend bit, subtract divisor when it fits
  for (genvar k = 0; k < WORD_W; k++) begin : g_step
    word_t           rem_in;
    word_t           bits_in;
    logic            valid_in;
    logic [WORD_W:0] trial;
    logic [WORD_W:0] diff;

    // First stage takes the ports, the others the previous stage
    if (k == 0) begin : g_head
      assign rem_in   = '0;
      assign bits_in  = dividend;
      assign valid_in = in_valid;
    end else begin : g_tail
      assign rem_in   = rem[k-1];
      assign bits_in  = bits[k-1];
      assign valid_in = valid[k-1];
    end

    assign trial = {rem_in, bits_in[WORD_W-1]};
    assign diff  = trial - {1'b0, divisor};

    always_ff @(posedge clk) begin
      if (rst) begin
        valid[k] <= 1'b0;
      end else if (en) begin
        valid[k] <= valid_in;
      end
      if (en) begin
        rem[k] <= diff[WORD_W] ? trial[WORD_W-1:0] : diff[WORD_W-1:0];
      end
    end

    // Remaining dividend bits move on to every stage but the last
    if (k < WORD_W-1) begin : g_shift
      always_ff @(posedge clk) begin
        if (en) begin
          bits[k] <= {bits_in[WORD_W-2:0], 1'b0};
        end
      end
    end
  end

  assign out_valid = valid[WORD_W-1];
  assign remainder = rem[WORD_W-1];

endmodule

// ===== sv/flow_tuple_bucket_hash.sv =====
// Top level: flow five-tuple to hash bucket index, fully pipelined.
//
// Usage:
//   tuple  - sink channel, one flow five-tuple per transfer.
//   bucket - source channel, one bucket_index per accepted tuple, in order.
//   cfg_we / cfg_wdata - write of bucket_count; write only while no tuple
//   is in flight. bucket_count of zero gives bucket_index zero.
// Stages: one seed/add stage, nine mix-line stages and 32 remainder
//   stages (one quotient bit each) lie between a tuple transfer and its
//   result on the bucket channel; the last is the output register.
// Throughput: one tuple per cycle unless stalled; the 32-stage remainder
//   pipeline and the mix stages each take a new item every enabled cycle.
// Stall: when a result waits and bucket.ready is low, the whole pipeline
//   holds and tuple.ready drops; nothing is lost or repeated. A free output
//   slot lets a new tuple in the same cycle the waiting result is taken.
// Reset: all stage valid bits clear, bucket_count returns to 1024.
`timescale 1ns / 1ps
module flow_tuple_bucket_hash (
  input  logic                   clk,
  input  logic                   rst,
  fthash_tuple_if.sink           tuple,
  fthash_bucket_if.source        bucket,
  input  logic                   cfg_we,
  input  fthash_pkg::word_t      cfg_wdata
);
  import fthash_pkg::*;

  word_t  bucket_count;
  logic   en;
  logic   mix_valid;
  word_t  mix_hash;
  logic   mod_valid;
  word_t  mod_rem;
  tuple_t tuple_data;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_count <= BUCKET_COUNT_RESET;
    end else if (cfg_we) begin
      bucket_count <= cfg_wdata;
    end
  end

  // Global advance: last stage empty or its result taken
  assign en          = !mod_valid || bucket.ready;
  assign tuple.ready = en;

  assign tuple_data.source_address      = tuple.source_address;
  assign tuple_data.destination_address = tuple.destination_address;
  assign tuple_data.source_port         = tuple.source_port;
  assign tuple_data.destination_port    = tuple.destination_port;
  assign tuple_data.protocol_number     = tuple.protocol_number;

  fthash_mix u_mix (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .in_valid     (tuple.valid),
    .tuple        (tuple_data),
    .bucket_count (bucket_count),
    .out_valid    (mix_valid),
    .hash         (mix_hash)
  );

  fthash_mod u_mod (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (mix_valid),
    .dividend  (mix_hash),
    .divisor   (bucket_count),
    .out_valid (mod_valid),
    .remainder (mod_rem)
  );

  // Zero bucket count forces index zero
  assign bucket.valid        = mod_valid;
  assign bucket.bucket_index = (bucket_count == '0) ? '0 : mod_rem;

endmodule
